[src/thst_pkg.sv]
// Package for the tick handler slot table: sizes, request codes and item types.
// No dependencies; used by tick_handler_slot_table_unit.
`timescale 1ns / 1ps
`default_nettype none

package thst_pkg;

   localparam int NUM_SLOTS   = 8;
   localparam int HANDLE_BITS = 16;

   // slot address and scan counter widths (counter also holds NUM_SLOTS)
   localparam int SLOT_BITS = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_BITS  = $clog2(NUM_SLOTS + 1);

   typedef enum logic [1:0] {
      OP_TICK     = 2'd0,
      OP_REGISTER = 2'd1,
      OP_REMOVE   = 2'd2,
      OP_NONE     = 2'd3
   } thst_op_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] handle;
   } thst_req_type;

   typedef struct packed {
      logic        ok;
      logic        has_call;
      logic [15:0] call_handle;
      logic [2:0]  slot_index;
      logic        last;
   } thst_rsp_type;

endpackage : thst_pkg

`default_nettype wire

[src/tick_handler_slot_table_unit.sv]
// Tick handler slot table: top level, control sequencer and output register.
// Depends on thst_pkg and thst_ram.
`timescale 1ns / 1ps
`default_nettype none

//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------------
//  req     | in  | req_valid/req_ready  | req_type (tick/register/remove), handle
//  rsp     | out | rsp_valid/rsp_ready  | ok, has_call, call_handle, slot_index, last
//
// Scan: register and remove scan all NUM_SLOTS entries, one RAM read a cycle.
//   A tick reads only the occupied slots, each in ST_TICK_RD then ST_TICK_DATA,
//   and steps past empty slots; the registered RAM read port sets this.
// Reset: occupancy lives in one valid bit per slot, cleared at once by reset; no
//   clearing pass. An entry without its valid bit reads as an empty slot.
// Stalls: a result sits in the output register while the next item is taken;
//   the sequencer only waits when it must load a new result into a full register.

module tick_handler_slot_table_unit
   import thst_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_ready,
   input  wire thst_req_type  req_data,
   output      logic          rsp_valid,
   input  wire logic          rsp_ready,
   output      thst_rsp_type  rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_TICK_RD,
      ST_TICK_DATA,
      ST_COMMIT
   } state_type;

   // control and sequencing
   state_type               state_ff,        state_in;
   thst_op_type             op_ff,           op_in;
   logic [HANDLE_BITS-1:0]  handle_ff,       handle_in;
   logic [CNT_BITS-1:0]     idx_ff,          idx_in;
   // read in flight during a scan
   logic                    eval_ff,         eval_in;
   logic [SLOT_BITS-1:0]    eval_idx_ff,     eval_idx_in;
   logic                    eval_occ_ff,     eval_occ_in;
   // scan findings
   logic                    match_found_ff,  match_found_in;
   logic [SLOT_BITS-1:0]    match_idx_ff,    match_idx_in;
   logic                    empty_found_ff,  empty_found_in;
   logic [SLOT_BITS-1:0]    empty_idx_ff,    empty_idx_in;
   // per-slot occupancy
   logic [NUM_SLOTS-1:0]    valid_ff,        valid_in;
   // output register
   logic                    rsp_valid_ff,    rsp_valid_in;
   thst_rsp_type            rsp_data_ff,     rsp_data_in;

   // RAM port
   logic                    ram_wr_en;
   logic [SLOT_BITS-1:0]    ram_wr_addr;
   logic                    ram_rd_en;
   logic [SLOT_BITS-1:0]    ram_rd_addr;
   logic [HANDLE_BITS-1:0]  ram_rd_data;

   logic                    out_free;
   logic                    more_after;
   logic [HANDLE_BITS-1:0]  eval_value;
   logic [SLOT_BITS-1:0]    idx_slot;

   thst_ram #(
      .WIDTH (HANDLE_BITS),
      .DEPTH (NUM_SLOTS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (handle_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign idx_slot  = idx_ff[SLOT_BITS-1:0];

   // slot just read; an unoccupied slot reads as zero
   assign eval_value = eval_occ_ff ? ram_rd_data : '0;

   // any occupied slot above the current tick position
   always_comb begin
      more_after = 1'b0;
      for (int j = 0; j < NUM_SLOTS; j++) begin
         if (valid_ff[j] && (CNT_BITS'(j) > idx_ff)) begin
            more_after = 1'b1;
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      handle_in      = handle_ff;
      idx_in         = idx_ff;
      eval_in        = 1'b0;
      eval_idx_in    = eval_idx_ff;
      eval_occ_in    = eval_occ_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      empty_found_in = empty_found_ff;
      empty_idx_in   = empty_idx_ff;
      valid_in       = valid_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = empty_idx_ff;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = idx_slot;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in          = thst_op_type'(req_data.req_type);
               handle_in      = HANDLE_BITS'(req_data.handle);
               idx_in         = '0;
               match_found_in = 1'b0;
               empty_found_in = 1'b0;
               case (thst_op_type'(req_data.req_type))
                  OP_TICK:     state_in = (valid_ff == '0) ? ST_COMMIT : ST_TICK_RD;
                  OP_REGISTER: state_in = ST_SCAN;
                  OP_REMOVE:   state_in = ST_SCAN;
                  default:     state_in = ST_COMMIT;
               endcase
            end
         end

         ST_SCAN: begin
            // issue one read a cycle, judge the previous one
            if (idx_ff < CNT_BITS'(NUM_SLOTS)) begin
               ram_rd_en   = 1'b1;
               eval_in     = 1'b1;
               eval_idx_in = idx_slot;
               eval_occ_in = valid_ff[idx_slot];
               idx_in      = idx_ff + 1'b1;
            end
            if (eval_ff) begin
               if ((eval_value == handle_ff) && !match_found_ff) begin
                  match_found_in = 1'b1;
                  match_idx_in   = eval_idx_ff;
               end
               if (!eval_occ_ff && !empty_found_ff) begin
                  empty_found_in = 1'b1;
                  empty_idx_in   = eval_idx_ff;
               end
               if (idx_ff == CNT_BITS'(NUM_SLOTS)) begin
                  state_in = ST_COMMIT;
               end
            end
         end

         ST_TICK_RD: begin
            if (idx_ff >= CNT_BITS'(NUM_SLOTS)) begin
               state_in = ST_IDLE;
            end else if (valid_ff[idx_slot]) begin
               ram_rd_en = 1'b1;
               state_in  = ST_TICK_DATA;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         ST_TICK_DATA: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.ok          = 1'b1;
               rsp_data_in.has_call    = 1'b1;
               rsp_data_in.call_handle = 16'(ram_rd_data);
               rsp_data_in.slot_index  = 3'(idx_ff);
               rsp_data_in.last        = !more_after;
               idx_in                  = idx_ff + 1'b1;
               state_in                = more_after ? ST_TICK_RD : ST_IDLE;
            end
         end

         ST_COMMIT: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.ok          = 1'b0;
               rsp_data_in.has_call    = 1'b0;
               rsp_data_in.call_handle = '0;
               rsp_data_in.slot_index  = '0;
               rsp_data_in.last        = 1'b1;
               state_in                = ST_IDLE;
               case (op_ff)
                  OP_TICK: begin
                     // empty table
                     rsp_data_in.ok = 1'b1;
                  end
                  OP_REGISTER: begin
                     if (match_found_ff) begin
                        rsp_data_in.ok         = 1'b1;
                        rsp_data_in.slot_index = 3'(match_idx_ff);
                     end else if (empty_found_ff) begin
                        ram_wr_en               = 1'b1;
                        valid_in[empty_idx_ff]  = 1'b1;
                        rsp_data_in.ok          = 1'b1;
                        rsp_data_in.slot_index  = 3'(empty_idx_ff);
                     end
                  end
                  OP_REMOVE: begin
                     if (match_found_ff) begin
                        valid_in[match_idx_ff] = 1'b0;
                        rsp_data_in.ok         = 1'b1;
                        rsp_data_in.slot_index = 3'(match_idx_ff);
                     end
                  end
                  default: begin
                     rsp_data_in.ok = 1'b0;
                  end
               endcase
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      handle_ff      <= handle_in;
      idx_ff         <= idx_in;
      eval_ff        <= eval_in;
      eval_idx_ff    <= eval_idx_in;
      eval_occ_ff    <= eval_occ_in;
      match_found_ff <= match_found_in;
      match_idx_ff   <= match_idx_in;
      empty_found_ff <= empty_found_in;
      empty_idx_ff   <= empty_idx_in;
      rsp_data_ff    <= rsp_data_in;
   end

endmodule : tick_handler_slot_table_unit

`default_nettype wire

[src/thst_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module thst_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  wire logic                                          clock,
   input  wire logic                                          wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  wire logic [WIDTH-1:0]                              wr_data,
   input  wire logic                                          rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output      logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : thst_ram

`default_nettype wire
